FILE: hw/rtl/ifhg_pkg.sv
package ifhg_pkg;

  localparam int unsigned FRAG_PAYLOAD = 1480;
  localparam int unsigned HDR_BYTES    = 20;
  localparam int unsigned HDR_WORDS    = 5;
  localparam int unsigned IP_VERSION   = 4;

  localparam logic [15:0] FRAG_PAYLOAD_W = 16'(FRAG_PAYLOAD);
  localparam logic [15:0] HDR_BYTES_W    = 16'(HDR_BYTES);
  localparam logic [15:0] VER_IHL_WORD   = 16'((IP_VERSION << 12) | (HDR_WORDS << 8));

  localparam logic REG_SOURCE_IP    = 1'b0;
  localparam logic REG_TIME_TO_LIVE = 1'b1;

  localparam logic [7:0] TTL_RESET = 8'd64;

  typedef struct packed {
    logic capture;
    logic prep;
    logic emit;
  } ifhg_cmd_t;

  typedef struct packed {
    logic last_frag;
    logic out_free;
  } ifhg_status_t;

endpackage

FILE: hw/rtl/ifhg_ctrl.sv
module ifhg_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ifhg_pkg::ifhg_status_t status,
  output ifhg_pkg::ifhg_cmd_t    cmd
);
  import ifhg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.prep    = 1'b0;
    cmd.emit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_frag) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/ifhg_dp.sv
module ifhg_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ifhg_pkg::ifhg_cmd_t    cmd,
  output ifhg_pkg::ifhg_status_t status,
  input  logic [31:0]            source_ip,
  input  logic [7:0]             time_to_live,
  input  logic [15:0]            in_payload_len,
  input  logic [31:0]            in_dst_ip,
  input  logic [7:0]             in_protocol,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [10:0]            out_total_length,
  output logic [12:0]            out_frag_offset,
  output logic                   out_more_fragments,
  output logic [15:0]            out_ident,
  output logic [15:0]            out_hdr_checksum,
  output logic [31:0]            out_dst_ip_out,
  output logic [7:0]             out_protocol_out,
  output logic                   out_last
);
  import ifhg_pkg::*;

  logic [15:0] next_ident_r, next_ident_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [15:0] byte_off_r, byte_off_nxt;
  logic [31:0] dst_r;
  logic [7:0]  proto_r;
  logic [15:0] ident_r;
  logic [15:0] base_sum_r;
  logic        out_valid_r, out_valid_nxt;

  logic [10:0] tot_len_r;
  logic [12:0] frag_off_r;
  logic        mf_r;
  logic [15:0] ident_out_r;
  logic [15:0] csum_r;
  logic [31:0] dst_out_r;
  logic [7:0]  proto_out_r;
  logic        last_r;

  logic [18:0] base_raw;
  logic [16:0] base_f1;
  logic [15:0] base_f2;
  logic        more;
  logic [15:0] piece;
  logic [15:0] tot_len;
  logic [15:0] flags_off;
  logic [17:0] frag_raw;
  logic [16:0] frag_f1;
  logic [15:0] frag_f2;

  assign base_raw = 19'(VER_IHL_WORD) + 19'(ident_r) + 19'({time_to_live, proto_r})
                  + 19'(source_ip[31:16]) + 19'(source_ip[15:0])
                  + 19'(dst_r[31:16]) + 19'(dst_r[15:0]);
  assign base_f1  = 17'(base_raw[15:0]) + 17'(base_raw[18:16]);
  assign base_f2  = base_f1[15:0] + 16'(base_f1[16]);

  assign more      = remaining_r > FRAG_PAYLOAD_W;
  assign piece     = more ? FRAG_PAYLOAD_W : remaining_r;
  assign tot_len   = piece + HDR_BYTES_W;
  assign flags_off = {2'b00, more, byte_off_r[15:3]};
  assign frag_raw  = 18'(base_sum_r) + 18'(tot_len) + 18'(flags_off);
  assign frag_f1   = 17'(frag_raw[15:0]) + 17'(frag_raw[17:16]);
  assign frag_f2   = frag_f1[15:0] + 16'(frag_f1[16]);

  assign status.last_frag = !more;
  assign status.out_free  = !out_valid_r || out_ready;

  always_comb begin
    next_ident_nxt = next_ident_r;
    remaining_nxt  = remaining_r;
    byte_off_nxt   = byte_off_r;
    out_valid_nxt  = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.capture) begin
      next_ident_nxt = next_ident_r + 16'd1;
      remaining_nxt  = in_payload_len;
      byte_off_nxt   = '0;
    end
    if (cmd.emit) begin
      remaining_nxt = remaining_r - piece;
      byte_off_nxt  = byte_off_r + piece;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_ident_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      next_ident_r <= next_ident_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remaining_r <= remaining_nxt;
    byte_off_r  <= byte_off_nxt;
    if (cmd.capture) begin
      dst_r   <= in_dst_ip;
      proto_r <= in_protocol;
      ident_r <= next_ident_r;
    end
    if (cmd.prep) begin
      base_sum_r <= base_f2;
    end
    if (cmd.emit) begin
      tot_len_r   <= tot_len[10:0];
      frag_off_r  <= byte_off_r[15:3];
      mf_r        <= more;
      ident_out_r <= ident_r;
      csum_r      <= ~frag_f2;
      dst_out_r   <= dst_r;
      proto_out_r <= proto_r;
      last_r      <= !more;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_total_length   = tot_len_r;
  assign out_frag_offset    = frag_off_r;
  assign out_more_fragments = mf_r;
  assign out_ident          = ident_out_r;
  assign out_hdr_checksum   = csum_r;
  assign out_dst_ip_out     = dst_out_r;
  assign out_protocol_out   = proto_out_r;
  assign out_last           = last_r;

endmodule

FILE: hw/rtl/ipv4_fragment_header_gen.sv
// Transmit-side IPv4 header generator with fragmentation.
// The input channel takes one request word: payload length, destination
// address and protocol. The output channel gives one header descriptor word
// per fragment, with last set on the final one of the request.
// Payloads above 1480 bytes are split into 1480-byte fragments with MF set,
// and the remainder goes last with MF clear.
// The request is captured, the prep state sums the base checksum, and the
// emit state loads the first descriptor into the output register; further
// descriptors follow one per cycle while out_ready is high. A request gives
// at most 45 fragments, all emitted by the fragment loop in the emit state.
// The next request is taken in the cycle after its last descriptor is loaded,
// even while that descriptor still waits in the output register.
// When the receiver stalls, the output register holds its word and the
// fragment loop pauses until the word is taken.
// Reset clears the identification counter and source address to zero, TTL to
// 64. The user must write the source address and TTL over the APB port at
// byte addresses 0 and 4 only while the block is idle; it does not check.
module ipv4_fragment_header_gen (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_payload_len,
  input  logic [31:0] in_dst_ip,
  input  logic [7:0]  in_protocol,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_total_length,
  output logic [12:0] out_frag_offset,
  output logic        out_more_fragments,
  output logic [15:0] out_ident,
  output logic [15:0] out_hdr_checksum,
  output logic [31:0] out_dst_ip_out,
  output logic [7:0]  out_protocol_out,
  output logic        out_last
);
  import ifhg_pkg::*;

  logic [31:0]  source_ip_r;
  logic [7:0]   ttl_r;
  logic         wr_en;
  ifhg_cmd_t    cmd;
  ifhg_status_t status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_ip_r <= '0;
      ttl_r       <= TTL_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SOURCE_IP:    source_ip_r <= pwdata;
        REG_TIME_TO_LIVE: ttl_r       <= pwdata[7:0];
        default:          source_ip_r <= source_ip_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SOURCE_IP:    prdata = source_ip_r;
      REG_TIME_TO_LIVE: prdata = {24'd0, ttl_r};
      default:          prdata = '0;
    endcase
  end

  ifhg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ifhg_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .source_ip          (source_ip_r),
    .time_to_live       (ttl_r),
    .in_payload_len     (in_payload_len),
    .in_dst_ip          (in_dst_ip),
    .in_protocol        (in_protocol),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_total_length   (out_total_length),
    .out_frag_offset    (out_frag_offset),
    .out_more_fragments (out_more_fragments),
    .out_ident          (out_ident),
    .out_hdr_checksum   (out_hdr_checksum),
    .out_dst_ip_out     (out_dst_ip_out),
    .out_protocol_out   (out_protocol_out),
    .out_last           (out_last)
  );

endmodule

FILE: tb/sv/ipv4_fragment_header_checker.sv
`timescale 1ns / 100ps

module ipv4_fragment_header_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_payload_len,
  input  logic [31:0] in_dst_ip,
  input  logic [7:0]  in_protocol,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [10:0] out_total_length,
  input  logic [12:0] out_frag_offset,
  input  logic        out_more_fragments,
  input  logic [15:0] out_ident,
  input  logic [15:0] out_hdr_checksum,
  input  logic [31:0] out_dst_ip_out,
  input  logic [7:0]  out_protocol_out,
  input  logic        out_last,
  output int unsigned fail_count,
  output int unsigned pending_words
);
  import ifhg_pkg::*;

  localparam logic [2:0] SRC_ADDR = {REG_SOURCE_IP, 2'b00};
  localparam logic [2:0] TTL_ADDR = {REG_TIME_TO_LIVE, 2'b00};

  typedef struct packed {
    logic [10:0] total_length;
    logic [12:0] frag_offset;
    logic        more_fragments;
    logic [15:0] ident;
    logic [15:0] hdr_csum;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic        last;
  } frag_hdr_t;

  frag_hdr_t   pending_hdrs[$];
  frag_hdr_t   head;
  logic [31:0] src_ip;
  logic [7:0]  ttl_val;
  logic [15:0] next_ident;
  int unsigned errors = 0;

  function automatic logic [15:0] calc_hdr_csum(logic [15:0] tot, logic [15:0] ident,
                                                logic [15:0] flags, logic [7:0] proto,
                                                logic [31:0] dst);
    logic [31:0] acc;
    acc = 32'(VER_IHL_WORD) + 32'(tot) + 32'(ident) + 32'(flags) + 32'({ttl_val, proto})
        + 32'(src_ip[31:16]) + 32'(src_ip[15:0]) + 32'(dst[31:16]) + 32'(dst[15:0]);
    acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  function automatic void predict_fragments(logic [15:0] len, logic [31:0] dst,
                                            logic [7:0] proto);
    int unsigned remaining;
    int unsigned piece;
    int unsigned byte_off;
    logic [15:0] tot16;
    bit          done;
    frag_hdr_t   h;
    remaining = len;
    byte_off = 0;
    done = 1'b0;
    while (!done) begin
      if (remaining > FRAG_PAYLOAD) begin
        piece = FRAG_PAYLOAD;
        h.more_fragments = 1'b1;
      end else begin
        piece = remaining;
        h.more_fragments = 1'b0;
        done = 1'b1;
      end
      tot16 = 16'(piece + HDR_BYTES);
      h.total_length = tot16[10:0];
      h.frag_offset = 13'(byte_off / 8);
      h.ident = next_ident;
      h.hdr_csum = calc_hdr_csum(tot16, next_ident,
                                 {2'b00, h.more_fragments, h.frag_offset}, proto, dst);
      h.dst_ip = dst;
      h.protocol = proto;
      h.last = done;
      pending_hdrs.push_back(h);
      remaining -= piece;
      byte_off += piece;
    end
    next_ident = next_ident + 16'd1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      src_ip = '0;
      ttl_val = TTL_RESET;
      next_ident = '0;
      pending_hdrs.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == SRC_ADDR) begin
            src_ip = pwdata;
          end else if (paddr == TTL_ADDR) begin
            ttl_val = pwdata[7:0];
          end
        end else if (paddr == SRC_ADDR) begin
          check_field("prdata", src_ip, prdata);
        end else if (paddr == TTL_ADDR) begin
          check_field("prdata", {24'd0, ttl_val}, prdata);
        end
      end
      if (in_valid && in_ready) begin
        predict_fragments(in_payload_len, in_dst_ip, in_protocol);
      end
      if (out_valid && out_ready) begin
        if (pending_hdrs.size() == 0) begin
          $error("Header word arrived with no request outstanding.");
          errors++;
        end else begin
          head = pending_hdrs.pop_front();
          check_field("total_length", 32'(head.total_length), 32'(out_total_length));
          check_field("frag_offset", 32'(head.frag_offset), 32'(out_frag_offset));
          check_field("more_fragments", 32'(head.more_fragments), 32'(out_more_fragments));
          check_field("ident", 32'(head.ident), 32'(out_ident));
          check_field("out_hdr_checksum", 32'(head.hdr_csum), 32'(out_hdr_checksum));
          check_field("dst_ip_out", head.dst_ip, out_dst_ip_out);
          check_field("protocol_out", 32'(head.protocol), 32'(out_protocol_out));
          check_field("last", 32'(head.last), 32'(out_last));
        end
      end
    end
    fail_count <= errors;
    pending_words <= pending_hdrs.size();
  end

endmodule

FILE: tb/sv/tb_ipv4_fragment_header_gen.sv
`timescale 1ns / 100ps

module tb_ipv4_fragment_header_gen;
  import ifhg_pkg::*;

  localparam logic [2:0] SRC_ADDR = {REG_SOURCE_IP, 2'b00};
  localparam logic [2:0] TTL_ADDR = {REG_TIME_TO_LIVE, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_payload_len = '0;
  logic [31:0] in_dst_ip = '0;
  logic [7:0]  in_protocol = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] out_total_length;
  logic [12:0] out_frag_offset;
  logic        out_more_fragments;
  logic [15:0] out_ident;
  logic [15:0] out_hdr_checksum;
  logic [31:0] out_dst_ip_out;
  logic [7:0]  out_protocol_out;
  logic        out_last;
  int unsigned fail_count;
  int unsigned pending_words;

  int unsigned burst_left = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall_left = 0;

  always #5 clk = ~clk;

  ipv4_fragment_header_gen u_dut (.*);

  ipv4_fragment_header_checker u_checker (.*);

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(16, 200);
    end else begin
      rx_mode_left--;
    end
    if (rx_steady || rx_mode == 0) begin
      out_ready <= 1'b1;
    end else begin
      case (rx_mode)
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (rx_stall_left != 0) begin
            rx_stall_left--;
            out_ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            rx_stall_left = $urandom_range(1, 20);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic send_request(input logic [15:0] len, input logic [31:0] dst,
                              input logic [7:0] proto);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_payload_len <= len;
    in_dst_ip <= dst;
    in_protocol <= proto;
    do @(posedge clk); while (!in_ready);
    if (!tx_steady) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic program_config(input logic [31:0] src, input logic [7:0] ttl);
    apb_access(1'b1, SRC_ADDR, src);
    apb_access(1'b1, TTL_ADDR, {24'd0, ttl});
    apb_access(1'b0, SRC_ADDR, '0);
    apb_access(1'b0, TTL_ADDR, '0);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [15:0] pick_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 16'($urandom_range(0, FRAG_PAYLOAD));
    if (sel < 75) return 16'($urandom_range(FRAG_PAYLOAD + 1, 4 * FRAG_PAYLOAD));
    if (sel < 85) return 16'($urandom_range(1, 44) * FRAG_PAYLOAD + $urandom_range(0, 2) - 1);
    if (sel < 95) return 16'($urandom_range(0, 65535));
    return 16'(65535 - $urandom_range(0, 1));
  endfunction

  function automatic logic [31:0] pick_dst();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [15:0] dir_len[18];
    logic [31:0] src;
    logic [7:0]  ttl;
    dir_len = '{16'd0, 16'd1, 16'd7, 16'd8, 16'd9, 16'd1479, 16'd1480, 16'd1481, 16'd2959,
                16'd2960, 16'd2961, 16'd4440, 16'd30000, 16'd65119, 16'd65120, 16'd65121,
                16'd65534, 16'd65535};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    apb_access(1'b0, SRC_ADDR, '0);
    apb_access(1'b0, TTL_ADDR, '0);
    psel <= 1'b0;
    penable <= 1'b0;

    foreach (dir_len[i]) begin
      case (i % 3)
        0: send_request(dir_len[i], 32'h0000_0000, 8'h00);
        1: send_request(dir_len[i], 32'hFFFF_FFFF, 8'hFF);
        default: send_request(dir_len[i], $urandom, 8'($urandom_range(0, 255)));
      endcase
    end
    drain();

    // Back-to-back single-fragment requests with the receiver always ready.
    program_config($urandom, 8'($urandom_range(0, 255)));
    tx_steady = 1'b1;
    rx_steady <= 1'b1;
    repeat (20) send_request(16'($urandom_range(0, FRAG_PAYLOAD)), $urandom,
                             8'($urandom_range(0, 255)));
    drain();
    tx_steady = 1'b0;
    rx_steady <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src = 32'hFFFF_FFFF;
          ttl = 8'hFF;
        end
        1: begin
          src = 32'h0000_0000;
          ttl = 8'h00;
        end
        2: begin
          src = $urandom;
          ttl = 8'($urandom_range(0, 255));
        end
        default: begin
          src = 32'hC0A8_0001;
          ttl = 8'h01;
        end
      endcase
      program_config(src, ttl);
      repeat (70) send_request(pick_len(), pick_dst(), 8'($urandom_range(0, 255)));
      drain();
    end

    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ifhg_pkg.sv
hw/rtl/ifhg_ctrl.sv
hw/rtl/ifhg_dp.sv
hw/rtl/ipv4_fragment_header_gen.sv
tb/sv/ipv4_fragment_header_checker.sv
tb/sv/tb_ipv4_fragment_header_gen.sv
